// File: sv/assert_macros.svh
// Assertion macros shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset.
`define LCDF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("lcdf assertion failed");
// Check that a condition never holds at a clock edge outside reset.
`define LCDF_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("lcdf forbidden condition seen");
`else
`define LCDF_ASSERT(lbl, clk, rstn, prop)
`define LCDF_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: sv/lcdf_pkg.sv
// Types, constants and helpers shared by the LCD text framer modules.
package lcdf_pkg;

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] CMD_BASIC = 8'h30;
    localparam logic [7:0] PAD_CHAR  = 8'h20;

    // Work for one character, as handed from the front to the back.
    typedef struct packed {
        logic       init;      // send basic-instruction command and start address
        logic       addr_cmd;  // send the cell address before the character
        logic       pad;       // pad the pair with a space
        logic [7:0] addr;      // cell address byte
        logic [7:0] ch;        // character byte
    } lcdf_job_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } lcdf_qstat_t;

    typedef enum logic [2:0] {
        PH_INIT,
        PH_START,
        PH_ADDR,
        PH_CHAR,
        PH_PAD
    } lcdf_phase_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'h90;
            2'd2:    base = 8'h88;
            default: base = 8'h98;
        endcase
        return base;
    endfunction

    function automatic logic [23:0] make_frame(input logic data, input logic [7:0] b);
        logic [7:0] sync;
        sync = data ? SYNC_DATA : SYNC_CMD;
        return {sync, b[7:4], 4'h0, b[3:0], 4'h0};
    endfunction

endpackage

// File: sv/lcdf_front.sv
// Front end: accepts characters, tracks the cursor and builds one job per word.
module lcdf_front
    import lcdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        first_char,
    input  logic        last_char,
    input  logic [1:0]  start_row,
    input  logic [2:0]  start_col,
    input  lcdf_qstat_t q_stat,
    output logic        push,
    output lcdf_job_t   job
);

    logic [1:0] cursor_row_reg, cursor_row_next;
    logic [3:0] cursor_col_reg, cursor_col_next;
    logic       second_reg, second_next;

    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        logic [1:0] row;
        logic [3:0] col;
        logic       sop;
        row = first_char ? start_row : cursor_row_reg;
        col = first_char ? {1'b0, start_col} : cursor_col_reg;
        sop = first_char ? 1'b0 : second_reg;

        job.init     = first_char;
        job.addr_cmd = !sop;
        job.pad      = 1'b0;
        job.ch       = char_code;
        if (!sop)
        begin
            // wrap the column into the next row before addressing the cell
            if (col[3])
            begin
                col = 4'd0;
                row = row + 2'd1;
            end
            if (last_char)
            begin
                job.pad = 1'b1;
                sop     = 1'b0;
            end
            else
            begin
                sop = 1'b1;
            end
        end
        else
        begin
            sop = 1'b0;
        end
        job.addr = row_base(row) | {5'd0, col[2:0]};
        if (!job.addr_cmd || job.pad)
            col = col + 4'd1;

        cursor_row_next = row;
        cursor_col_next = col;
        second_next     = sop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            second_reg     <= 1'b0;
        end
        else if (push)
        begin
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            second_reg     <= second_next;
        end
    end

endmodule

// File: sv/lcdf_fifo.sv
// Short job queue between the front and back ends.
`include "assert_macros.svh"
module lcdf_fifo
    import lcdf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  lcdf_job_t   wr_job,
    input  logic        pop,
    output lcdf_job_t   rd_job,
    output lcdf_qstat_t q_stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lcdf_job_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign q_stat.full  = (count_reg == FULL_CNT);
    assign q_stat.empty = (count_reg == '0);
    assign rd_job       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `LCDF_NEVER(a_push_full, clk, rst_n, push && q_stat.full)
    `LCDF_NEVER(a_pop_empty, clk, rst_n, pop && q_stat.empty)

endmodule

// File: sv/lcdf_back.sv
// Back end: steps through each job and issues one frame a cycle while a job is queued and out_stall is low.
`include "assert_macros.svh"
module lcdf_back
    import lcdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcdf_job_t   head,
    input  lcdf_qstat_t q_stat,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] frame_word,
    output logic        is_data,
    output logic        last_of_run
);

    lcdf_phase_t phase_reg, phase_next, cur_phase, step_phase;
    logic        active_reg, active_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] frame_reg;
    logic        is_data_reg, last_reg;
    logic        load, fire, f_data, f_last;
    logic [7:0]  f_byte;

    assign load = !out_valid_reg || !out_stall;
    assign fire = load && !q_stat.empty;
    assign pop  = fire && f_last;

    always_comb
    begin
        if (active_reg)
            cur_phase = phase_reg;
        else if (head.init)
            cur_phase = PH_INIT;
        else if (head.addr_cmd)
            cur_phase = PH_ADDR;
        else
            cur_phase = PH_CHAR;

        f_byte     = PAD_CHAR;
        f_data     = 1'b1;
        f_last     = 1'b1;
        step_phase = PH_INIT;
        case (cur_phase)
            PH_INIT:
            begin
                f_byte     = CMD_BASIC;
                f_data     = 1'b0;
                f_last     = 1'b0;
                step_phase = PH_START;
            end
            PH_START:
            begin
                f_byte     = head.addr;
                f_data     = 1'b0;
                f_last     = 1'b0;
                step_phase = PH_ADDR;
            end
            PH_ADDR:
            begin
                f_byte     = head.addr;
                f_data     = 1'b0;
                f_last     = 1'b0;
                step_phase = PH_CHAR;
            end
            PH_CHAR:
            begin
                f_byte     = head.ch;
                f_last     = !head.pad;
                step_phase = PH_PAD;
            end
            default:
            begin
                f_byte     = PAD_CHAR;
            end
        endcase

        phase_next     = phase_reg;
        active_next    = active_reg;
        out_valid_next = load ? fire : out_valid_reg;
        if (fire)
        begin
            phase_next  = step_phase;
            active_next = !f_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            frame_reg   <= make_frame(f_data, f_byte);
            is_data_reg <= f_data;
            last_reg    <= f_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_word  = frame_reg;
    assign is_data     = is_data_reg;
    assign last_of_run = last_reg;

    `LCDF_ASSERT(a_active_has_head, clk, rst_n, active_reg |-> !q_stat.empty)
    `LCDF_ASSERT(a_cmd_not_last, clk, rst_n, (out_valid_reg && !is_data_reg) |-> !last_reg)

endmodule

// File: sv/lcd_text_stream_framer.sv
// Top level of the LCD text framer: front end, job queue and back end.
// An accepted word is written into the job queue, then its first frame into the output register.
// Throughput: one word a cycle in while the queue is not full, one frame a cycle out while
//   out_stall is low and a job is queued; a word costs 1 to 5 frames from the back-end sequencer.
// Reset (rst_n low, asynchronous): cursor to row 0 column 0, pair state cleared,
//   queue emptied and output register invalidated.
module lcd_text_stream_framer
    import lcdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character words in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        first_char,
    input  logic        last_char,
    input  logic [1:0]  start_row,
    input  logic [2:0]  start_col,
    // serial frames out
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] frame_word,
    output logic        is_data,
    output logic        last_of_run
);

    // The front end resolves the cursor for each word and pushes a job that says
    // which frames to send; the back end drains jobs a frame at a time into a
    // registered output; a stall on either side holds up the other only once the queue is empty or full.
    lcdf_job_t   push_job, head_job;
    lcdf_qstat_t q_stat;
    logic        push, pop;

    lcdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .first_char (first_char),
        .last_char  (last_char),
        .start_row  (start_row),
        .start_col  (start_col),
        .q_stat     (q_stat),
        .push       (push),
        .job        (push_job)
    );

    // Hold queued jobs while the back end is busy with an earlier word.
    lcdf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (head_job),
        .q_stat (q_stat)
    );

    // Advance through init, start address, cell address, character and pad frames.
    lcdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .is_data     (is_data),
        .last_of_run (last_of_run)
    );

endmodule

// File: dv/tb_lcd_text_stream_framer.sv
// Self-checking testbench for the LCD text stream framer: random and directed strings.
`timescale 1ns / 1ps

module tb_lcd_text_stream_framer;
    import lcdf_pkg::*;

    // Cell address bases, one per display row.
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'h90;
    localparam logic [7:0] ROW2_BASE = 8'h88;
    localparam logic [7:0] ROW3_BASE = 8'h98;

    localparam int unsigned RANDOM_WORDS = 112;
    localparam int unsigned MAX_GAP      = 18;
    localparam int unsigned LONG_HOLD    = 300;   // receiver hold-off, long enough to fill the queue
    localparam int unsigned STALL_LIMIT  = 2000;  // cycles with no handshake at all
    localparam int unsigned DRAIN_CYCLES = 20;

    // One character word as offered on the input side, with its lead-in gap.
    typedef struct packed {
        logic [7:0] code;
        logic       first;
        logic       last;
        logic [1:0] row;
        logic [2:0] col;
        logic [4:0] gap;
    } char_word_t;

    // One serial frame as expected on the output side.
    typedef struct packed {
        logic [23:0] word;
        logic        data;
        logic        last;
    } lcd_frame_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [7:0]  char_code   = '0;
    logic        first_char  = 1'b0;
    logic        last_char   = 1'b0;
    logic [1:0]  start_row   = '0;
    logic [2:0]  start_col   = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [23:0] frame_word;
    logic        is_data;
    logic        last_of_run;

    char_word_t  pending_words[$];
    lcd_frame_t  expected_frames[$];
    char_word_t  word_on_bus;

    // Cursor and pair state of the display, tracked alongside the block.
    logic [1:0]  cur_row   = '0;
    logic [3:0]  cur_col   = '0;
    logic        pair_open = 1'b0;

    int unsigned gap_left    = 0;
    bit          gap_loaded  = 1'b0;
    int unsigned out_wait    = 0;
    int unsigned quiet_left  = 0;
    int unsigned frames_seen = 0;
    int unsigned idle_cycles = 0;
    int unsigned fail_count  = 0;

    lcd_text_stream_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .first_char  (first_char),
        .last_char   (last_char),
        .start_row   (start_row),
        .start_col   (start_col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_word  (frame_word),
        .is_data     (is_data),
        .last_of_run (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Address byte of a cell; the column is taken modulo 8.
    function automatic logic [7:0] cell_address(input logic [1:0] row, input logic [3:0] col);
        logic [7:0] base;
        case (row)
            2'd0:    base = ROW0_BASE;
            2'd1:    base = ROW1_BASE;
            2'd2:    base = ROW2_BASE;
            default: base = ROW3_BASE;
        endcase
        return base | {5'd0, col[2:0]};
    endfunction

    // Queue one frame: sync byte, high nibble, low nibble shifted up.
    function automatic void push_frame(input logic data, input logic [7:0] b);
        lcd_frame_t f;
        f.word = {(data ? SYNC_DATA : SYNC_CMD), b[7:4], 4'h0, b[3:0], 4'h0};
        f.data = data;
        f.last = 1'b0;
        expected_frames.push_back(f);
    endfunction

    // Work out the frames one accepted character word causes and advance the cursor.
    task automatic predict_frames(input char_word_t w);
        lcd_frame_t tail;
        if (w.first)
        begin
            // A new string reloads the cursor and drops any half-sent pair.
            cur_row   = w.row;
            cur_col   = {1'b0, w.col};
            pair_open = 1'b0;
            push_frame(1'b0, CMD_BASIC);
            push_frame(1'b0, cell_address(cur_row, cur_col));
        end
        if (!pair_open)
        begin
            // Wrap the column past the row end, and the row past the bottom.
            if (cur_col >= 4'd8)
            begin
                cur_col = '0;
                cur_row = cur_row + 2'd1;
            end
            push_frame(1'b0, cell_address(cur_row, cur_col));
            push_frame(1'b1, w.code);
            if (w.last)
            begin
                // Odd-length string: pad the pair with a space.
                push_frame(1'b1, PAD_CHAR);
                cur_col   = cur_col + 4'd1;
                pair_open = 1'b0;
            end
            else
                pair_open = 1'b1;
        end
        else
        begin
            push_frame(1'b1, w.code);
            cur_col   = cur_col + 4'd1;
            pair_open = 1'b0;
        end
        // Flag the final frame of this word.
        tail = expected_frames.pop_back();
        tail.last = 1'b1;
        expected_frames.push_back(tail);
    endtask

    // Driver: offer words from the pending queue, hold each until taken,
    // and insert the word's own gap before raising valid.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_code  <= '0;
            first_char <= 1'b0;
            last_char  <= 1'b0;
            start_row  <= '0;
            start_col  <= '0;
            gap_left   = 0;
            gap_loaded = 1'b0;
        end
        else
        begin
            // Predict at the edge where the word is accepted.
            if (in_valid && !in_stall)
                predict_frames(word_on_bus);
            // Hold a stalled word; otherwise idle or advance to the next one.
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                    in_valid <= 1'b0;
                else if (!gap_loaded && pending_words[0].gap != 0)
                begin
                    gap_left   = pending_words[0].gap - 1;
                    gap_loaded = 1'b1;
                    in_valid   <= 1'b0;
                end
                else
                begin
                    word_on_bus = pending_words.pop_front();
                    gap_loaded  = 1'b0;
                    in_valid   <= 1'b1;
                    char_code  <= word_on_bus.code;
                    first_char <= word_on_bus.first;
                    last_char  <= word_on_bus.last;
                    start_row  <= word_on_bus.row;
                    start_col  <= word_on_bus.col;
                end
            end
        end
    end

    // Monitor: check each accepted frame against the oldest expectation,
    // then draw how long to stall before taking the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_wait  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                lcd_frame_t exp_frame;
                frames_seen = frames_seen + 1;
                if (expected_frames.size() == 0)
                begin
                    $error("frame_word: unexpected frame %h", frame_word);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    exp_frame = expected_frames.pop_front();
                    if (frame_word !== exp_frame.word)
                    begin
                        $error("frame_word: expected %h, got %h", exp_frame.word, frame_word);
                        fail_count = fail_count + 1;
                    end
                    if (is_data !== exp_frame.data)
                    begin
                        $error("is_data: expected %b, got %b", exp_frame.data, is_data);
                        fail_count = fail_count + 1;
                    end
                    if (last_of_run !== exp_frame.last)
                    begin
                        $error("last_of_run: expected %b, got %b", exp_frame.last, last_of_run);
                        fail_count = fail_count + 1;
                    end
                end
                // Hold off for a long stretch twice so the block backs up to its input.
                if (frames_seen == 100 || frames_seen == 180)
                    out_wait = LONG_HOLD;
                else if (quiet_left != 0)
                begin
                    quiet_left = quiet_left - 1;
                    out_wait   = 0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    quiet_left = $urandom_range(20, 40);
                    out_wait   = 0;
                end
                else
                    out_wait = $urandom_range(0, MAX_GAP);
            end
            if (out_wait != 0)
            begin
                out_stall <= 1'b1;
                out_wait  = out_wait - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if no word and no frame moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
            begin
                idle_cycles = idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("tb_lcd_text_stream_framer: errors");
                    $finish;
                end
            end
        end
    end

    task automatic add_word(input logic [7:0] code, input logic first, input logic last,
                            input logic [1:0] row, input logic [2:0] col, input bit burst);
        char_word_t w;
        w.code  = code;
        w.first = first;
        w.last  = last;
        w.row   = row;
        w.col   = col;
        w.gap   = burst ? 5'd0 : 5'($urandom_range(0, MAX_GAP));
        pending_words.push_back(w);
    endtask

    // Queue a string with random content; a cut string never gets its last marker.
    task automatic add_string(input int unsigned len, input bit burst, input bit cut);
        for (int unsigned i = 0; i < len; i++)
            add_word(8'($urandom), i == 0, !cut && i == len - 1,
                     2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), burst);
    endtask

    initial
    begin
        int unsigned random_words;
        int unsigned len;
        bit          burst;

        // Continue from the reset cursor with no leading first character.
        add_word(8'h41, 1'b0, 1'b0, 2'd3, 3'd5, 1'b0);
        add_word(8'h42, 1'b0, 1'b0, 2'd1, 3'd2, 1'b0);
        // Single-character string at the last cell: pad with a space.
        add_word(8'h00, 1'b1, 1'b1, 2'd3, 3'd7, 1'b0);
        // Continue past the bottom-right cell: wrap column and row to the top.
        add_word(8'hFF, 1'b0, 1'b0, 2'd0, 3'd0, 1'b1);
        add_word(8'h7E, 1'b0, 1'b1, 2'd2, 3'd4, 1'b1);
        // Drop a half-sent pair when a new string starts.
        add_word(8'h78, 1'b1, 1'b0, 2'd1, 3'd2, 1'b0);
        add_word(8'h71, 1'b1, 1'b0, 2'd2, 3'd0, 1'b0);
        add_word(8'h72, 1'b0, 1'b1, 2'd0, 3'd0, 1'b0);
        // One-character string with all-ones fields.
        add_word(8'hFF, 1'b1, 1'b1, 2'd3, 3'd7, 1'b0);
        // One-character string with all-zero position.
        add_word(8'h55, 1'b1, 1'b1, 2'd0, 3'd0, 1'b1);
        // Even string that crosses the row end.
        add_word(8'h61, 1'b1, 1'b0, 2'd1, 3'd7, 1'b1);
        add_word(8'h62, 1'b0, 1'b0, 2'd0, 3'd0, 1'b1);
        add_word(8'h63, 1'b0, 1'b0, 2'd3, 3'd7, 1'b1);
        add_word(8'h64, 1'b0, 1'b1, 2'd2, 3'd1, 1'b1);
        // Odd string ending in a pad.
        add_word(8'h65, 1'b1, 1'b0, 2'd2, 3'd3, 1'b0);
        add_word(8'hAA, 1'b0, 1'b0, 2'd1, 3'd6, 1'b0);
        add_word(8'h67, 1'b0, 1'b1, 2'd0, 3'd1, 1'b0);
        // Lone last character on the first half of a pair, no first marker.
        add_word(8'h80, 1'b0, 1'b1, 2'd1, 3'd1, 1'b0);

        // Mostly well-formed strings with random content, some bursts with no gaps,
        // plus noise words and strings cut short.
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                add_word(8'($urandom), 1'($urandom), 1'($urandom),
                         2'($urandom), 3'($urandom), burst);
                random_words = random_words + 1;
            end
            else
            begin
                len = $urandom_range(1, 9);
                add_string(len, burst, $urandom_range(0, 5) == 0);
                random_words = random_words + len;
            end
        end

        // Hold reset low at the start, then release it once.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to be taken and every frame to arrive.
        while (pending_words.size() != 0 || in_valid || expected_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_frames.size() != 0)
        begin
            $error("frame_word: %0d expected frames never arrived", expected_frames.size());
            fail_count = fail_count + 1;
        end
        if (fail_count == 0)
            $display("tb_lcd_text_stream_framer: clean");
        else
            $display("tb_lcd_text_stream_framer: errors");
        $finish;
    end

endmodule
